FILE: hw/rtl/gtg_pkg.sv
// Shared types, constants and the arctangent table of the go-to-goal steering unit.
package gtg_pkg;

    // Vectoring iterations and table size
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int ROT_STEPS    = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int STEP_W       = $clog2(ATAN_LEN);

    // Datapath widths
    localparam int POS_W   = 16;
    localparam int VEC_W   = 24;  // CORDIC x and y, Q8.12 with growth headroom
    localparam int ANG_W   = 21;  // angle accumulator, Q.16
    localparam int MB_W    = 17;  // second multiplier operand
    localparam int PROD_W  = VEC_W + MB_W;
    localparam int DIST_W  = 19;
    localparam int BEAR_W  = 17;
    localparam int ERR_W   = 18;
    localparam int LIN_W   = 19;
    localparam int RATE_W  = 20;
    localparam int GAIN_W  = 12;

    // Fixed-point constants
    localparam logic signed [ANG_W-1:0] PI_Q16       = 21'sd205887;
    localparam logic signed [MB_W-1:0]  INV_GAIN_Q16 = 17'sd39797;
    localparam logic signed [PROD_W-1:0] DIST_RND    = PROD_W'(64'sd524288);
    localparam logic signed [PROD_W-1:0] GAIN_RND    = PROD_W'(64'sd128);
    localparam logic signed [PROD_W-1:0] LIN_MAX     = PROD_W'(64'sd524287);
    localparam logic signed [PROD_W-1:0] ANG_MAX     = PROD_W'(64'sd524287);
    localparam logic signed [PROD_W-1:0] ANG_MIN     = PROD_W'(-64'sd524288);

    // Register indexes
    localparam int CFG_AW = 3;
    typedef enum logic [CFG_AW-1:0] {
        REG_GOAL_X     = 3'd0,
        REG_GOAL_Y     = 3'd1,
        REG_TOLERANCE  = 3'd2,
        REG_SPEED_GAIN = 3'd3,
        REG_TURN_GAIN  = 3'd4
    } t_reg_idx;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT,
        S_MDIST,
        S_RDIST,
        S_MLIN,
        S_MANG,
        S_DONE
    } t_state;

    // Multiplier operand select
    typedef enum logic [1:0] {
        MUL_DIST,
        MUL_LIN,
        MUL_ANG
    } t_mul_sel;

    // atan(2^-i) in Q.16
    function automatic logic [15:0] f_atan(input logic [STEP_W-1:0] idx);
        logic [15:0] v;
        unique case (idx)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30385;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/go_to_goal_steering_unit.sv
// Go-to-goal proportional steering: CORDIC distance and bearing, gains and arrival.
//
// One pose word (x, y, heading) produces one command word (linear speed, angular rate,
// arrived flag). The offset to the goal is folded into the right half-plane and run
// through one shared shift-add CORDIC stage for CORDIC_STEPS iterations (16), then one
// shared multiplier forms, in turn, the gain-corrected distance, the speed and the turn
// rate. A word passes through the rotation states, the distance multiply, the rounding,
// the speed multiply and the turn-rate multiply, and reaches the result register from
// the done state; the next word is accepted only once the sequencer is back in idle, so
// the input is not ready during that time, and further while a finished result still
// waits for the output register to empty. Once a pose lies within the arrival tolerance
// the arrived flag sticks and every later command is zero until reset. Registers: 0 goal
// x, 1 goal y, 2 tolerance, 3 speed gain, 4 turn gain; other indexes are ignored.
module go_to_goal_steering_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write port
    input  logic                         i_cfg_we,
    input  logic [gtg_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [15:0]                  i_cfg_wdata,
    // Pose stream
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [47:0]                  i_s_axis_tdata,  // pose_x, pose_y, pose_heading
    // Command stream
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [39:0]                  o_m_axis_tdata,  // linear_speed, angular_rate, pad
    output logic                         o_m_axis_tuser   // arrived
);
    import gtg_pkg::*;

    // Configuration registers
    logic signed [POS_W-1:0] r_goal_x, r_goal_y;
    logic [POS_W-1:0]        r_tol;
    logic [GAIN_W-1:0]       r_speed_gain, r_turn_gain;

    // Sequencer and datapath
    t_state                  r_state, n_state;
    logic [STEP_W-1:0]       r_step;
    logic signed [VEC_W-1:0] r_x, r_y;
    logic signed [ANG_W-1:0] r_z;
    logic                    r_zero;
    logic signed [POS_W-1:0] r_heading;
    logic signed [PROD_W-1:0] r_prod;
    logic [DIST_W-1:0]       r_dist;
    logic signed [ERR_W-1:0] r_err;
    logic [LIN_W-1:0]        r_lin;
    logic                    r_reached;

    // Output register
    logic                    r_out_valid;
    logic [LIN_W-1:0]        r_out_lin;
    logic signed [RATE_W-1:0] r_out_ang;
    logic                    r_out_arr;

    // Control from the output decoder
    t_mul_sel                mul_sel;
    logic                    in_accept;
    logic                    out_free;
    logic                    load_out;
    logic                    last_step;

    // Combinational datapath
    logic signed [POS_W:0]   dx, dy;
    logic signed [VEC_W-1:0] x0, y0;
    logic signed [ANG_W-1:0] z0;
    logic signed [VEC_W-1:0] xs, ys;
    logic signed [ANG_W-1:0] atan_v;
    logic signed [VEC_W-1:0] mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] dist_sum;
    logic signed [ANG_W-1:0] bear_sum;
    logic signed [BEAR_W-1:0] bearing;
    logic signed [PROD_W-1:0] gain_sum, gain_shr;
    logic [LIN_W-1:0]        lin_sat;
    logic signed [RATE_W-1:0] ang_sat;
    logic                    arrive_now;

    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign last_step = (r_step == STEP_W'(ROT_STEPS - 1));

    // Offset to goal, folded into the right half-plane
    always_comb begin
        dx = {r_goal_x[POS_W-1], r_goal_x} - {i_s_axis_tdata[15], i_s_axis_tdata[15:0]};
        dy = {r_goal_y[POS_W-1], r_goal_y} - {i_s_axis_tdata[31], i_s_axis_tdata[31:16]};
        if (dx[POS_W]) begin
            x0 = VEC_W'(-dx) <<< 4;
            y0 = VEC_W'(-dy) <<< 4;
            z0 = dy[POS_W] ? -PI_Q16 : PI_Q16;
        end else begin
            x0 = VEC_W'(dx) <<< 4;
            y0 = VEC_W'(dy) <<< 4;
            z0 = '0;
        end
    end

    // One CORDIC micro-rotation
    assign xs     = r_x >>> r_step;
    assign ys     = r_y >>> r_step;
    assign atan_v = ANG_W'(f_atan(r_step));

    // Shared multiplier operands
    always_comb begin
        unique case (mul_sel)
            MUL_LIN: begin
                mul_a = VEC_W'(r_dist);
                mul_b = MB_W'(r_speed_gain);
            end
            MUL_ANG: begin
                mul_a = VEC_W'(r_err);
                mul_b = MB_W'(r_turn_gain);
            end
            default: begin
                mul_a = r_x;
                mul_b = INV_GAIN_Q16;
            end
        endcase
    end
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Distance and bearing rounding
    assign dist_sum = r_prod + DIST_RND;
    assign bear_sum = r_z + ANG_W'(8);
    assign bearing  = r_zero ? '0 : BEAR_W'(bear_sum >>> 4);

    // Gain rounding and saturation
    assign gain_sum = r_prod + GAIN_RND;
    assign gain_shr = gain_sum >>> 8;
    always_comb begin
        lin_sat = (gain_shr > LIN_MAX) ? LIN_W'(LIN_MAX) : LIN_W'(gain_shr);
        priority if (gain_shr > ANG_MAX) begin
            ang_sat = RATE_W'(ANG_MAX);
        end else if (gain_shr < ANG_MIN) begin
            ang_sat = RATE_W'(ANG_MIN);
        end else begin
            ang_sat = RATE_W'(gain_shr);
        end
    end
    assign arrive_now = r_reached || (r_dist <= DIST_W'(r_tol));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_s_axis_tvalid) n_state = S_ROT;
            S_ROT:   if (last_step) n_state = S_MDIST;
            S_MDIST: n_state = S_RDIST;
            S_RDIST: n_state = S_MLIN;
            S_MLIN:  n_state = S_MANG;
            S_MANG:  n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        mul_sel         = MUL_DIST;
        load_out        = 1'b0;
        unique case (r_state)
            S_IDLE:  o_s_axis_tready = 1'b1;
            S_MLIN:  mul_sel = MUL_LIN;
            S_MANG:  mul_sel = MUL_ANG;
            S_DONE:  load_out = out_free;
            default: mul_sel = MUL_DIST;
        endcase
    end
    assign in_accept = o_s_axis_tready && i_s_axis_tvalid;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x     <= 16'sd1280;
            r_goal_y     <= 16'sd1280;
            r_tol        <= 16'd3;
            r_speed_gain <= 12'd256;
            r_turn_gain  <= 12'd384;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_GOAL_X:     r_goal_x     <= i_cfg_wdata;
                REG_GOAL_Y:     r_goal_y     <= i_cfg_wdata;
                REG_TOLERANCE:  r_tol        <= i_cfg_wdata;
                REG_SPEED_GAIN: r_speed_gain <= i_cfg_wdata[GAIN_W-1:0];
                REG_TURN_GAIN:  r_turn_gain  <= i_cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_reached   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
                if (arrive_now) r_reached <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // Load the folded offset
        if (in_accept) begin
            r_x       <= x0;
            r_y       <= y0;
            r_z       <= z0;
            r_zero    <= (dx == '0) && (dy == '0);
            r_heading <= i_s_axis_tdata[47:32];
            r_step    <= '0;
        end
        // Rotate toward the x axis
        if (r_state == S_ROT) begin
            if (!r_y[VEC_W-1]) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_v;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_v;
            end
            r_step <= r_step + STEP_W'(1);
        end
        // Shared multiplier
        if (r_state == S_MDIST || r_state == S_MLIN || r_state == S_MANG) begin
            r_prod <= mul_p;
        end
        // Round distance, form heading error
        if (r_state == S_RDIST) begin
            r_dist <= dist_sum[DIST_W+19:20];
            r_err  <= ERR_W'(bearing) - ERR_W'(r_heading);
        end
        // Hold saturated speed
        if (r_state == S_MANG) begin
            r_lin <= lin_sat;
        end
        // Fill the output register
        if (load_out) begin
            r_out_arr <= arrive_now;
            r_out_lin <= arrive_now ? '0 : r_lin;
            r_out_ang <= arrive_now ? '0 : ang_sat;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_ang, r_out_lin};
    assign o_m_axis_tuser  = r_out_arr;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the go-to-goal steering unit: pose words in, command words checked.
module tb_top;

    localparam int WATCHDOG_LIMIT = 4000;   // quiet cycles before the run is declared hung
    localparam int DRAIN_CYCLES   = 40;     // more than one word's latency
    localparam int LONG_HOLD      = 300;    // one long command-side stall
    localparam int MAX_PRINT      = 40;
    localparam logic [gtg_pkg::CFG_AW-1:0] REG_UNUSED = 3'd7;

    localparam longint PI_Q16       = 205887;
    localparam longint INV_GAIN_Q16 = 39797;
    localparam longint SPEED_MAX    = 524287;
    localparam longint RATE_MAX     = 524287;
    localparam longint RATE_MIN     = -524288;

    // Pose word, x in the lowest bits
    typedef struct packed {
        logic signed [15:0] heading;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } pose_t;

    // Command word as seen on tdata and tuser
    typedef struct packed {
        logic               arrived;
        logic signed [19:0] rate;
        logic [18:0]        speed;
    } cmd_t;

    typedef struct packed {
        logic signed [63:0] distance;
        logic signed [63:0] bear;
    } polar_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [gtg_pkg::CFG_AW-1:0] i_cfg_addr = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata = '0;     // pose_x, pose_y, pose_heading
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;          // linear_speed, angular_rate, pad
    logic        o_m_axis_tuser;          // arrived

    // Shadow of the register file and the sticky arrival state
    logic signed [15:0] goal_x_q = 16'sd1280;
    logic signed [15:0] goal_y_q = 16'sd1280;
    logic [15:0]        tol_q = 16'd3;
    logic [11:0]        speed_gain_q = 12'd256;
    logic [11:0]        turn_gain_q = 12'd384;
    bit                 reached_q = 1'b0;

    pose_t pending_poses[$];
    cmd_t  expected_cmds[$];
    int    words_queued = 0;
    int    words_checked = 0;
    int    settings_cnt = 0;
    int    err_cnt = 0;
    int    drv_idle_pct = 0;
    int    rdy_idle_pct = 0;

    go_to_goal_steering_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Free-running clock, 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // atan(2^-i) in Q.16
    function automatic longint atan_q16(input int i);
        case (i)
            0:       return 51472;
            1:       return 30385;
            2:       return 16055;
            3:       return 8150;
            4:       return 4091;
            5:       return 2047;
            6:       return 1024;
            7:       return 512;
            8:       return 256;
            9:       return 128;
            10:      return 64;
            11:      return 32;
            12:      return 16;
            13:      return 8;
            14:      return 4;
            15:      return 2;
            16:      return 1;
            default: return 0;
        endcase
    endfunction

    // Distance (Q8.8) and bearing (Q4.12) from a pose to the current goal
    function automatic polar_t goal_polar(input pose_t p);
        longint dx, dy, x, y, z, xs, ys;
        int     i;
        polar_t r;
        dx = longint'(goal_x_q) - longint'(p.x);
        dy = longint'(goal_y_q) - longint'(p.y);
        z  = 0;
        // Fold the left half-plane over, starting the angle at +/- pi
        if (dx < 0) begin
            z = (dy >= 0) ? PI_Q16 : -PI_Q16;
            x = -dx;
            y = -dy;
        end else begin
            x = dx;
            y = dy;
        end
        x = x * 16;
        y = y * 16;
        for (i = 0; i < gtg_pkg::CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_q16(i);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_q16(i);
            end
        end
        r.bear     = (dx == 0 && dy == 0) ? 64'sd0 : (z + 8) >>> 4;
        r.distance = (x * INV_GAIN_Q16 + (longint'(1) <<< 19)) >>> 20;
        return r;
    endfunction

    // Command expected for one pose under the shadow settings
    function automatic cmd_t steer_cmd(input pose_t p);
        polar_t pol;
        longint distance, lin, err, ang;
        cmd_t   c;
        pol      = goal_polar(p);
        distance = pol.distance;
        c        = '0;
        if (reached_q || distance <= longint'(tol_q)) begin
            c.arrived = 1'b1;
        end else begin
            lin = (distance * longint'(speed_gain_q) + 128) >>> 8;
            if (lin < 0) lin = 0;
            if (lin > SPEED_MAX) lin = SPEED_MAX;
            err = longint'(pol.bear) - longint'(p.heading);
            ang = (err * longint'(turn_gain_q) + 128) >>> 8;
            if (ang > RATE_MAX) ang = RATE_MAX;
            if (ang < RATE_MIN) ang = RATE_MIN;
            c.speed = lin[18:0];
            c.rate  = ang[19:0];
        end
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_PRINT) $display("tb_top mismatch: %s", msg);
    endtask

    task automatic queue_pose(input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] h);
        pose_t p;
        p.x = x;
        p.y = y;
        p.heading = h;
        pending_poses.push_back(p);
        words_queued++;
    endtask

    // Random poses: mostly anywhere, some close to the goal or on its axes
    task automatic queue_random_poses(input int n, input bit keep_away);
        pose_t  p;
        polar_t pol;
        int     kind, span, off, tries;
        bit     ok;
        repeat (n) begin
            ok    = 1'b0;
            tries = 0;
            while (!ok) begin
                kind = (tries >= 10) ? 0 : $urandom_range(99, 0);
                p.heading = 16'($urandom);
                if ($urandom_range(9, 0) == 0) p.heading = $urandom_range(1, 0) ? 16'sh7FFF
                                                                             : 16'sh8000;
                if (kind < 55) begin
                    p.x = 16'($urandom);
                    p.y = 16'($urandom);
                end else if (kind < 85) begin
                    span = 1 << $urandom_range(12, 0);
                    off  = $urandom_range(2 * span, 0) - span;
                    p.x  = goal_x_q + off[15:0];
                    off  = $urandom_range(2 * span, 0) - span;
                    p.y  = goal_y_q + off[15:0];
                end else if ($urandom_range(1, 0)) begin
                    p.x = goal_x_q;
                    p.y = 16'($urandom);
                end else begin
                    p.x = 16'($urandom);
                    p.y = goal_y_q;
                end
                pol = goal_polar(p);
                ok  = !keep_away || (longint'(pol.distance) > longint'(tol_q));
                tries++;
            end
            pending_poses.push_back(p);
            words_queued++;
        end
    endtask

    task automatic write_reg(input logic [gtg_pkg::CFG_AW-1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            gtg_pkg::REG_GOAL_X:     goal_x_q = val;
            gtg_pkg::REG_GOAL_Y:     goal_y_q = val;
            gtg_pkg::REG_TOLERANCE:  tol_q = val;
            gtg_pkg::REG_SPEED_GAIN: speed_gain_q = val[11:0];
            gtg_pkg::REG_TURN_GAIN:  turn_gain_q = val[11:0];
            default: ;
        endcase
    endtask

    // Write every register, with junk above the gain bits and at an unused index
    task automatic apply_setting(input logic [15:0] gx, input logic [15:0] gy,
                                 input logic [15:0] tol, input logic [11:0] sg,
                                 input logic [11:0] tg);
        logic [3:0] junk;
        junk = 4'($urandom);
        write_reg(gtg_pkg::REG_GOAL_X, gx);
        write_reg(gtg_pkg::REG_GOAL_Y, gy);
        write_reg(gtg_pkg::REG_TOLERANCE, tol);
        write_reg(gtg_pkg::REG_SPEED_GAIN, {junk, sg});
        write_reg(gtg_pkg::REG_TURN_GAIN, {~junk, tg});
        write_reg(REG_UNUSED, 16'($urandom));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_cnt++;
    endtask

    task automatic wait_drained();
        while (words_checked != words_queued) @(posedge i_clk);
    endtask

    // Pose driver: predict on each accepted word, then offer the next one
    always @(posedge i_clk) begin : drive_poses
        int   gap_left;
        cmd_t want;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                want = steer_cmd(pose_t'(i_s_axis_tdata));
                if (want.arrived) reached_q = 1'b1;
                expected_cmds.push_back(want);
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_poses.size() > 0 &&
                             $urandom_range(99, 0) < drv_idle_pct) begin
                    gap_left = $urandom_range(11, 1) - 1;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_poses.size() > 0) begin
                    i_s_axis_tdata  <= pending_poses.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Command monitor: check each accepted word, then choose the next ready
    always @(posedge i_clk) begin : check_cmds
        int   gap_left;
        int   hold_left;
        bit   hold_done;
        cmd_t got, want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            gap_left  = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.speed   = o_m_axis_tdata[18:0];
                got.rate    = o_m_axis_tdata[38:19];
                got.arrived = o_m_axis_tuser;
                if (expected_cmds.size() == 0) begin
                    report_mismatch($sformatf("unexpected word: speed %0d rate %0d arrived %0b",
                                              got.speed, $signed(got.rate), got.arrived));
                end else begin
                    want = expected_cmds.pop_front();
                    if (got.speed !== want.speed || got.rate !== want.rate ||
                        got.arrived !== want.arrived)
                        report_mismatch($sformatf(
                            "word %0d: speed %0d/%0d rate %0d/%0d arrived %0b/%0b (got/exp)",
                            words_checked, got.speed, want.speed, $signed(got.rate),
                            $signed(want.rate), got.arrived, want.arrived));
                    words_checked++;
                end
            end
            // One long stall so the unit backs up into its input
            if (!hold_done && words_checked >= 120) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                i_m_axis_tready <= 1'b0;
            end else if ($urandom_range(99, 0) < rdy_idle_pct) begin
                gap_left = $urandom_range(11, 1) - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin : watchdog
        int quiet;
        if (!i_rst_n || i_cfg_we || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet = 0;
        end else if (quiet + 1 >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet++;
        end
    end

    initial begin : sequencer
        int         ph;
        logic [15:0] gx, gy, tol;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: both half-planes, the goal's axes, field extremes
        drv_idle_pct = 15;
        rdy_idle_pct = 15;
        queue_pose(16'sh0000, 16'sh0000, 16'sh0000);
        queue_pose(16'sh8000, 16'sh8000, 16'sh7FFF);
        queue_pose(16'sh7FFF, 16'sh7FFF, 16'sh8000);
        queue_pose(16'sh7FFF, 16'sh8000, 16'sh1000);
        queue_pose(16'sd1280, 16'sh0000, 16'sh0000);
        queue_pose(16'sd1280, 16'sh7FFF, 16'sh0000);
        queue_pose(16'sh0000, 16'sd1280, 16'sh0000);
        queue_pose(16'sh7FFF, 16'sd1280, 16'sh0000);
        wait_drained();

        // Far-corner goal, full gains: speed and positive rate saturate
        apply_setting(16'h8000, 16'h7FFF, 16'd0, 12'd4095, 12'd4095);
        queue_pose(16'sh7FFF, 16'sh8000, 16'sh8000);
        queue_pose(16'sh8000, 16'sh8000, 16'sh7FFF);
        queue_pose(16'sh7FFF, 16'sh7FFF, 16'sh0000);
        wait_drained();

        // Goal at origin: negative rate saturation and one-LSB offsets
        apply_setting(16'h0000, 16'h0000, 16'd0, 12'd4095, 12'd4095);
        queue_pose(16'sd100, 16'sd100, 16'sh7FFF);
        queue_pose(16'sd100, -16'sd100, 16'sh8000);
        queue_pose(16'sh0000, -16'sd1, 16'sh0000);
        queue_pose(-16'sd1, 16'sh0000, 16'sh0000);
        wait_drained();

        // Zero gains: zero commands without arrival
        apply_setting(16'($urandom), 16'($urandom), 16'd0, 12'd0, 12'd0);
        queue_random_poses(3, 1'b1);
        wait_drained();

        // Random settings and poses, idling varied per phase
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin drv_idle_pct = 20; rdy_idle_pct = 10; end
                1: begin drv_idle_pct = 0;  rdy_idle_pct = 0;  end
                2: begin drv_idle_pct = 40; rdy_idle_pct = 25; end
                3: begin drv_idle_pct = 5;  rdy_idle_pct = 30; end
                4: begin drv_idle_pct = 30; rdy_idle_pct = 5;  end
                default: begin drv_idle_pct = 0; rdy_idle_pct = 0; end
            endcase
            gx  = 16'($urandom);
            gy  = 16'($urandom);
            if (ph == 1) begin
                gx = $urandom_range(1, 0) ? 16'h7FFF : 16'h8000;
                gy = $urandom_range(1, 0) ? 16'h7FFF : 16'h8000;
            end
            tol = (ph % 2) ? 16'($urandom_range(2048, 0)) : 16'($urandom_range(3, 0));
            apply_setting(gx, gy, tol, (ph == 2) ? 12'd4095 : 12'($urandom_range(4095, 0)),
                          (ph == 3) ? 12'd4095 : 12'($urandom_range(4095, 0)));
            queue_random_poses(230, 1'b1);
            wait_drained();
        end

        // Arrival on a zero offset, then sticky through new goals and tolerances
        apply_setting(16'($urandom), 16'($urandom), 16'd3, 12'($urandom), 12'($urandom));
        queue_pose(goal_x_q, goal_y_q, 16'($urandom));
        queue_random_poses(15, 1'b0);
        wait_drained();
        apply_setting(16'($urandom), 16'($urandom), 16'd0, 12'($urandom), 12'($urandom));
        queue_random_poses(10, 1'b0);
        wait_drained();
        apply_setting(16'($urandom), 16'($urandom), 16'hFFFF, 12'd4095, 12'd4095);
        queue_random_poses(5, 1'b0);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_cmds.size() != 0)
            report_mismatch($sformatf("%0d expected words never arrived", expected_cmds.size()));
        $display("tb_top: %0d pose words checked under %0d register settings, %0d mismatches",
                 words_checked, settings_cnt, err_cnt);
        $display("tb_top: saturation, zero gains, axis and half-plane cases, a long output");
        $display("tb_top: stall, arrival on zero offset and sticky arrival were exercised");
        if (err_cnt == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
